@@ sv/vr_pkg.sv @@
`default_nettype none

package vr_pkg;

  // Fixed-point formats
  localparam int VEC_FRAC_BITS   = 14;
  localparam int RATIO_FRAC_BITS = 12;
  localparam int VEC_W           = 16;
  localparam int RATIO_W         = 16;

  // Intermediate widths, sized so that nothing wraps
  localparam int PROD_W = 2 * VEC_W;                      // inc_k * norm_k
  localparam int NEG_W  = PROD_W + 3;                     // -dot plus rounding half
  localparam int C_W    = (NEG_W - VEC_FRAC_BITS > VEC_FRAC_BITS + 2) ?
                          (NEG_W - VEC_FRAC_BITS) : (VEC_FRAC_BITS + 2);
  localparam int CN_W   = C_W + VEC_W + 1;                // c * norm_k, plus half
  localparam int CNR_W  = CN_W - VEC_FRAC_BITS;
  localparam int S_W    = ((CNR_W > VEC_W) ? CNR_W : VEC_W) + 1;
  localparam int ES_W   = S_W + RATIO_W + 2;              // eta * s, plus half
  localparam int P_W    = ES_W - RATIO_FRAC_BITS;
  localparam int Q_W    = VEC_FRAC_BITS + 3;              // clamped P_k
  localparam int SQ_W   = 2 * Q_W;                        // P_k squared
  localparam int SUM_W  = 2 * VEC_FRAC_BITS + 5;          // P.P
  localparam int K_W    = 2 * VEC_FRAC_BITS + 1;          // 1 - P.P
  localparam int R_W    = VEC_FRAC_BITS + 1;              // rounded root
  localparam int SN_W   = R_W + VEC_W + 2;                // root * norm_k, plus half
  localparam int SNR_W  = SN_W - VEC_FRAC_BITS;
  localparam int D_W    = ((P_W > SNR_W) ? P_W : SNR_W) + 1;

  // Square root pipeline: one result bit per step
  localparam int SQ_ITERS  = VEC_FRAC_BITS + 1;
  localparam int SQ_STEPS  = 3;
  localparam int SQ_STAGES = (SQ_ITERS + SQ_STEPS - 1) / SQ_STEPS;

  typedef logic        [VEC_W-1:0]   vraw_t;
  typedef logic        [RATIO_W-1:0] ratio_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [NEG_W-1:0]   neg_t;
  typedef logic signed [C_W-1:0]     c_t;
  typedef logic signed [CN_W-1:0]    cn_t;
  typedef logic signed [S_W-1:0]     s_t;
  typedef logic signed [ES_W-1:0]    es_t;
  typedef logic signed [P_W-1:0]     p_t;
  typedef logic signed [Q_W-1:0]     q_t;
  typedef logic signed [SQ_W-1:0]    sq_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic        [K_W-1:0]     k_t;
  typedef logic        [K_W:0]       ra_t;
  typedef logic        [R_W-1:0]     rt_t;
  typedef logic signed [SN_W-1:0]    sn_t;
  typedef logic signed [D_W-1:0]     d_t;

  // Constants in the width where they are used
  localparam neg_t C_ONE   = neg_t'(1) <<< VEC_FRAC_BITS;
  localparam neg_t C_HALF  = neg_t'(1) <<< (VEC_FRAC_BITS - 1);
  localparam cn_t  CN_HALF = cn_t'(1) <<< (VEC_FRAC_BITS - 1);
  localparam es_t  ES_HALF = es_t'(1) <<< (RATIO_FRAC_BITS - 1);
  localparam p_t   Q_LIM   = p_t'(1) <<< (VEC_FRAC_BITS + 1);
  localparam sum_t ONE_SQ  = sum_t'(1) <<< (2 * VEC_FRAC_BITS);
  localparam sn_t  SN_HALF = sn_t'(1) <<< (VEC_FRAC_BITS - 1);
  localparam d_t   SAT_HI  = d_t'((1 << (VEC_W - 1)) - 1);
  localparam d_t   SAT_LO  = d_t'(-(1 << (VEC_W - 1)));

  // Index 0 is x, 1 is y, 2 is z
  typedef struct packed {
    vraw_t [2:0] inc;
    vraw_t [2:0] norm;
    ratio_t      eta;
  } ray_t;

  typedef struct packed {
    vraw_t [2:0] inc;
    vraw_t [2:0] norm;
    ratio_t      eta;
    c_t          c;
  } cos_t;

  typedef struct packed {
    p_t    [2:0] p;
    vraw_t [2:0] norm;
    logic        tir;
    k_t          k;
  } perp_t;

  typedef struct packed {
    p_t    [2:0] p;
    vraw_t [2:0] norm;
    logic        tir;
  } rpay_t;

  typedef struct packed {
    p_t    [2:0] p;
    vraw_t [2:0] norm;
    logic        tir;
    rt_t         root;
  } root_t;

  typedef struct packed {
    vraw_t [2:0] v;
    logic        tir;
  } res_t;

endpackage

`default_nettype wire

@@ sv/vr_in_if.sv @@
`default_nettype none

// Ray channel: incident direction, normal and index ratio
interface vr_in_if;
  logic                valid;
  logic                ready;
  vr_pkg::vraw_t       inc_x;
  vr_pkg::vraw_t       inc_y;
  vr_pkg::vraw_t       inc_z;
  vr_pkg::vraw_t       norm_x;
  vr_pkg::vraw_t       norm_y;
  vr_pkg::vraw_t       norm_z;
  vr_pkg::ratio_t      index_ratio;

  modport source (
    output valid, inc_x, inc_y, inc_z, norm_x, norm_y, norm_z, index_ratio,
    input  ready
  );

  modport sink (
    input  valid, inc_x, inc_y, inc_z, norm_x, norm_y, norm_z, index_ratio,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/vr_out_if.sv @@
`default_nettype none

// Result channel: refracted direction and total reflection flag
interface vr_out_if;
  logic          valid;
  logic          ready;
  vr_pkg::vraw_t out_x;
  vr_pkg::vraw_t out_y;
  vr_pkg::vraw_t out_z;
  logic          total_reflection;

  modport source (
    output valid, out_x, out_y, out_z, total_reflection,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, total_reflection,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/vr_cosine.sv @@
`default_nettype none

// Cosine stages: products of incident and normal, then c = min(-I.N, 1)
module vr_cosine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  vr_pkg::ray_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output vr_pkg::cos_t   out_data
);

  logic [1:0]     vld_r;
  logic [1:0]     vin;
  logic [2:0]     rdy;
  vr_pkg::prod_t  prod_r [3];
  vr_pkg::ray_t   ray0_r;
  vr_pkg::ray_t   ray1_r;
  vr_pkg::c_t     c_r;
  vr_pkg::neg_t   negh;
  vr_pkg::neg_t   csh;
  vr_pkg::neg_t   cclamp;

  // Stage advances when empty or when the next one moves
  assign rdy[2] = out_ready;
  assign rdy[1] = !vld_r[1] || rdy[2];
  assign rdy[0] = !vld_r[0] || rdy[1];
  assign vin    = {vld_r[0], in_valid};
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < 2; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vin[k];
        end
      end
    end
  end

  // Stage 0: three signed products
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int j = 0; j < 3; j++) begin
        prod_r[j] <= vr_pkg::prod_t'($signed(in_data.inc[j])) *
                     vr_pkg::prod_t'($signed(in_data.norm[j]));
      end
      ray0_r <= in_data;
    end
  end

  // Stage 1: sum, negate, round half up, clamp above at one
  always_comb begin
    negh = vr_pkg::C_HALF - (vr_pkg::neg_t'(prod_r[0]) + vr_pkg::neg_t'(prod_r[1]) +
                             vr_pkg::neg_t'(prod_r[2]));
    csh  = negh >>> vr_pkg::VEC_FRAC_BITS;
    cclamp = (csh > vr_pkg::C_ONE) ? vr_pkg::C_ONE : csh;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      c_r    <= vr_pkg::c_t'(cclamp);
      ray1_r <= ray0_r;
    end
  end

  assign out_valid     = vld_r[1];
  assign out_data.inc  = ray1_r.inc;
  assign out_data.norm = ray1_r.norm;
  assign out_data.eta  = ray1_r.eta;
  assign out_data.c    = c_r;

endmodule

`default_nettype wire

@@ sv/vr_perp.sv @@
`default_nettype none

// Perpendicular part P = eta * (I + c*N), its squared length and k = 1 - P.P
module vr_perp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  vr_pkg::cos_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output vr_pkg::perp_t  out_data
);

  logic [4:0]       vld_r;
  logic [4:0]       vin;
  logic [5:0]       rdy;

  vr_pkg::cn_t      cn_r  [3];
  vr_pkg::vraw_t    inc0_r [3];
  vr_pkg::vraw_t    norm0_r [3];
  vr_pkg::ratio_t   eta0_r;

  vr_pkg::s_t       s_r   [3];
  vr_pkg::vraw_t    norm1_r [3];
  vr_pkg::ratio_t   eta1_r;

  vr_pkg::es_t      es_r  [3];
  vr_pkg::vraw_t    norm2_r [3];

  vr_pkg::sq_t      qq_r  [3];
  vr_pkg::p_t       p3_r  [3];
  vr_pkg::vraw_t    norm3_r [3];

  vr_pkg::perp_t    out_r;

  vr_pkg::p_t       p_rnd [3];
  vr_pkg::q_t       q_cl  [3];
  vr_pkg::sum_t     sum;

  // Bubble-collapsing ready chain
  assign rdy[5] = out_ready;
  for (genvar k = 0; k < 5; k++) begin : g_rdy
    assign rdy[k] = !vld_r[k] || rdy[k+1];
  end
  assign vin      = {vld_r[3:0], in_valid};
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < 5; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vin[k];
        end
      end
    end
  end

  // Stage 0: c * N_k
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int j = 0; j < 3; j++) begin
        cn_r[j]    <= vr_pkg::cn_t'(in_data.c) * vr_pkg::cn_t'($signed(in_data.norm[j]));
        inc0_r[j]  <= in_data.inc[j];
        norm0_r[j] <= in_data.norm[j];
      end
      eta0_r <= in_data.eta;
    end
  end

  // Stage 1: S_k = I_k + round(c * N_k)
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int j = 0; j < 3; j++) begin
        s_r[j] <= vr_pkg::s_t'($signed(inc0_r[j])) +
                  vr_pkg::s_t'((cn_r[j] + vr_pkg::CN_HALF) >>> vr_pkg::VEC_FRAC_BITS);
        norm1_r[j] <= norm0_r[j];
      end
      eta1_r <= eta0_r;
    end
  end

  // Stage 2: eta * S_k, ratio zero-extended
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int j = 0; j < 3; j++) begin
        es_r[j]    <= vr_pkg::es_t'(s_r[j]) * vr_pkg::es_t'(eta1_r);
        norm2_r[j] <= norm1_r[j];
      end
    end
  end

  // Stage 3: round to P_k, clamp for squaring, square
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      p_rnd[j] = vr_pkg::p_t'((es_r[j] + vr_pkg::ES_HALF) >>> vr_pkg::RATIO_FRAC_BITS);
      if (p_rnd[j] > vr_pkg::Q_LIM) begin
        q_cl[j] = vr_pkg::q_t'(vr_pkg::Q_LIM);
      end else if (p_rnd[j] < -vr_pkg::Q_LIM) begin
        q_cl[j] = vr_pkg::q_t'(-vr_pkg::Q_LIM);
      end else begin
        q_cl[j] = vr_pkg::q_t'(p_rnd[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int j = 0; j < 3; j++) begin
        qq_r[j]    <= vr_pkg::sq_t'(q_cl[j]) * vr_pkg::sq_t'(q_cl[j]);
        p3_r[j]    <= p_rnd[j];
        norm3_r[j] <= norm2_r[j];
      end
    end
  end

  // Stage 4: P.P against one; k = 1 - P.P
  assign sum = vr_pkg::sum_t'(qq_r[0]) + vr_pkg::sum_t'(qq_r[1]) + vr_pkg::sum_t'(qq_r[2]);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int j = 0; j < 3; j++) begin
        out_r.p[j]    <= p3_r[j];
        out_r.norm[j] <= norm3_r[j];
      end
      out_r.tir <= (sum > vr_pkg::ONE_SQ);
      out_r.k   <= vr_pkg::k_t'(vr_pkg::ONE_SQ - sum);
    end
  end

  assign out_valid = vld_r[4];
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ sv/vr_sqrt.sv @@
`default_nettype none

// Pipelined digit-by-digit square root of k, rounded to nearest
module vr_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  vr_pkg::perp_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output vr_pkg::root_t  out_data
);

  logic [vr_pkg::SQ_STAGES:0]   vld_r;
  logic [vr_pkg::SQ_STAGES:0]   vin;
  logic [vr_pkg::SQ_STAGES+1:0] rdy;

  vr_pkg::ra_t    rem_in  [vr_pkg::SQ_STAGES];
  vr_pkg::ra_t    acc_in  [vr_pkg::SQ_STAGES];
  vr_pkg::rpay_t  pay_in  [vr_pkg::SQ_STAGES];
  vr_pkg::ra_t    rem_nxt [vr_pkg::SQ_STAGES];
  vr_pkg::ra_t    acc_nxt [vr_pkg::SQ_STAGES];
  vr_pkg::ra_t    rem_r   [vr_pkg::SQ_STAGES];
  vr_pkg::ra_t    acc_r   [vr_pkg::SQ_STAGES];
  vr_pkg::rpay_t  pay_r   [vr_pkg::SQ_STAGES];
  vr_pkg::root_t  out_r;

  // Bubble-collapsing ready chain
  assign rdy[vr_pkg::SQ_STAGES+1] = out_ready;
  for (genvar k = 0; k <= vr_pkg::SQ_STAGES; k++) begin : g_rdy
    assign rdy[k] = !vld_r[k] || rdy[k+1];
  end
  assign vin      = {vld_r[vr_pkg::SQ_STAGES-1:0], in_valid};
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k <= vr_pkg::SQ_STAGES; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vin[k];
        end
      end
    end
  end

  // Each stage runs a few steps of the shift-subtract recurrence
  for (genvar g = 0; g < vr_pkg::SQ_STAGES; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign rem_in[g]      = vr_pkg::ra_t'(in_data.k);
      assign acc_in[g]      = '0;
      assign pay_in[g].p    = in_data.p;
      assign pay_in[g].norm = in_data.norm;
      assign pay_in[g].tir  = in_data.tir;
    end else begin : g_next
      assign rem_in[g] = rem_r[g-1];
      assign acc_in[g] = acc_r[g-1];
      assign pay_in[g] = pay_r[g-1];
    end

    always_comb begin : step_blk
      vr_pkg::ra_t rem_v;
      vr_pkg::ra_t acc_v;
      vr_pkg::ra_t bit_v;
      int          it;
      rem_v = rem_in[g];
      acc_v = acc_in[g];
      bit_v = '0;
      it    = 0;
      for (int t = 0; t < vr_pkg::SQ_STEPS; t++) begin
        it = g * vr_pkg::SQ_STEPS + t;
        if (it < vr_pkg::SQ_ITERS) begin
          bit_v = vr_pkg::ra_t'(1) << (2 * (vr_pkg::SQ_ITERS - 1 - it));
          if (rem_v >= acc_v + bit_v) begin
            rem_v = rem_v - (acc_v + bit_v);
            acc_v = (acc_v >> 1) + bit_v;
          end else begin
            acc_v = acc_v >> 1;
          end
        end
      end
      rem_nxt[g] = rem_v;
      acc_nxt[g] = acc_v;
    end

    always_ff @(posedge clk) begin
      if (rdy[g]) begin
        rem_r[g] <= rem_nxt[g];
        acc_r[g] <= acc_nxt[g];
        pay_r[g] <= pay_in[g];
      end
    end
  end

  // Last stage: round up when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (rdy[vr_pkg::SQ_STAGES]) begin
      out_r.p    <= pay_r[vr_pkg::SQ_STAGES-1].p;
      out_r.norm <= pay_r[vr_pkg::SQ_STAGES-1].norm;
      out_r.tir  <= pay_r[vr_pkg::SQ_STAGES-1].tir;
      if (rem_r[vr_pkg::SQ_STAGES-1] > acc_r[vr_pkg::SQ_STAGES-1]) begin
        out_r.root <= vr_pkg::rt_t'(acc_r[vr_pkg::SQ_STAGES-1] + vr_pkg::ra_t'(1));
      end else begin
        out_r.root <= vr_pkg::rt_t'(acc_r[vr_pkg::SQ_STAGES-1]);
      end
    end
  end

  assign out_valid = vld_r[vr_pkg::SQ_STAGES];
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ sv/vr_combine.sv @@
`default_nettype none

// Result = P - sqrt(k) * N, saturated; zero vector on total reflection
module vr_combine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  vr_pkg::root_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output vr_pkg::res_t   out_data
);

  logic [1:0]     vld_r;
  logic [1:0]     vin;
  logic [2:0]     rdy;
  vr_pkg::sn_t    sn_r [3];
  vr_pkg::p_t     p_r  [3];
  logic           tir_r;
  vr_pkg::d_t     diff [3];
  vr_pkg::res_t   out_r;

  assign rdy[2] = out_ready;
  assign rdy[1] = !vld_r[1] || rdy[2];
  assign rdy[0] = !vld_r[0] || rdy[1];
  assign vin    = {vld_r[0], in_valid};
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < 2; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vin[k];
        end
      end
    end
  end

  // Stage 0: root (unsigned) times N_k
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int j = 0; j < 3; j++) begin
        sn_r[j] <= vr_pkg::sn_t'(in_data.root) * vr_pkg::sn_t'($signed(in_data.norm[j]));
        p_r[j]  <= $signed(in_data.p[j]);
      end
      tir_r <= in_data.tir;
    end
  end

  // Stage 1: subtract rounded term, saturate, output register
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      diff[j] = vr_pkg::d_t'(p_r[j]) -
                vr_pkg::d_t'((sn_r[j] + vr_pkg::SN_HALF) >>> vr_pkg::VEC_FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int j = 0; j < 3; j++) begin
        if (tir_r) begin
          out_r.v[j] <= '0;
        end else if (diff[j] > vr_pkg::SAT_HI) begin
          out_r.v[j] <= vr_pkg::vraw_t'(vr_pkg::SAT_HI);
        end else if (diff[j] < vr_pkg::SAT_LO) begin
          out_r.v[j] <= vr_pkg::vraw_t'(vr_pkg::SAT_LO);
        end else begin
          out_r.v[j] <= vr_pkg::vraw_t'(diff[j]);
        end
      end
      out_r.tir <= tir_r;
    end
  end

  assign out_valid = vld_r[1];
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ sv/vector_refraction.sv @@
// Channel   Dir  Handshake           Payload
// in_ch     in   valid/ready (sink)  inc_x/y/z, norm_x/y/z (Q2.14), index_ratio (Q4.12)
// out_ch    out  valid/ready (src)   out_x/y/z (Q2.14, saturated), total_reflection
//
// One ray per cycle sustained while out_ch does not stall; the result path runs through
// cosine, perpendicular part, square root (three root bits per stage) and combine.
// rst_n is synchronous; it clears only the stage valid bits.
// Every stage holds its item while the next one is full and stalled; empty stages
// keep filling, so input is taken while a finished result waits on out_ch.
`default_nettype none

module vector_refraction (
  input  logic     clk,
  input  logic     rst_n,
  vr_in_if.sink    in_ch,
  vr_out_if.source out_ch
);

  vr_pkg::ray_t   ray;
  vr_pkg::cos_t   cos_d;
  vr_pkg::perp_t  perp_d;
  vr_pkg::root_t  root_d;
  vr_pkg::res_t   res_d;
  logic           cos_valid,  cos_ready;
  logic           perp_valid, perp_ready;
  logic           root_valid, root_ready;

  // Gather input fields, index 0 is x
  assign ray.inc  = {in_ch.inc_z, in_ch.inc_y, in_ch.inc_x};
  assign ray.norm = {in_ch.norm_z, in_ch.norm_y, in_ch.norm_x};
  assign ray.eta  = in_ch.index_ratio;

  vr_cosine u_cosine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (ray),
    .out_valid (cos_valid),
    .out_ready (cos_ready),
    .out_data  (cos_d)
  );

  vr_perp u_perp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cos_valid),
    .in_ready  (cos_ready),
    .in_data   (cos_d),
    .out_valid (perp_valid),
    .out_ready (perp_ready),
    .out_data  (perp_d)
  );

  vr_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (perp_valid),
    .in_ready  (perp_ready),
    .in_data   (perp_d),
    .out_valid (root_valid),
    .out_ready (root_ready),
    .out_data  (root_d)
  );

  vr_combine u_combine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (root_valid),
    .in_ready  (root_ready),
    .in_data   (root_d),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (res_d)
  );

  // Scatter result fields
  assign out_ch.out_x            = res_d.v[0];
  assign out_ch.out_y            = res_d.v[1];
  assign out_ch.out_z            = res_d.v[2];
  assign out_ch.total_reflection = res_d.tir;

endmodule

`default_nettype wire

@@ sv/vr_checker.sv @@
`default_nettype none

// Port-level checks for vector_refraction
module vr_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input vr_pkg::vraw_t out_x,
  input vr_pkg::vraw_t out_y,
  input vr_pkg::vraw_t out_z,
  input logic          total_reflection
);

  // A stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
      $stable(out_z) && $stable(total_reflection))
    else $error("result changed while stalled");

  // Total reflection always comes with the zero vector
  a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && total_reflection |-> out_x == '0 && out_y == '0 && out_z == '0)
    else $error("total reflection with nonzero vector");

  // With the output side free, the whole pipeline can move, so input is taken
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input blocked while output side is free");

  // Nothing left over from before reset
  a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind vector_refraction vr_checker u_vr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_x            (out_ch.out_x),
  .out_y            (out_ch.out_y),
  .out_z            (out_ch.out_z),
  .total_reflection (out_ch.total_reflection)
);

`default_nettype wire
